FILE: sv/acap_pkg.sv
// Shared types, codes and constants for the ANSI CSI attribute parser.
// Used by ansi_csi_attribute_parser_core; depends on nothing else.
package acap_pkg;

  typedef enum logic [3:0] {
    MODE_TEXT  = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_CSI   = 4'b0100,
    MODE_SPACE = 4'b1000
  } mode_t;

  typedef enum logic [3:0] {
    EV_PRINT   = 4'd0,
    EV_BEEP    = 4'd1,
    EV_TAB     = 4'd2,
    EV_CLS     = 4'd3,
    EV_NEWLINE = 4'd4,
    EV_RETURN  = 4'd5,
    EV_CLR_EOL = 4'd6,
    EV_COLUMN  = 4'd7,
    EV_COL_PIX = 4'd8,
    EV_SAVE    = 4'd9,
    EV_RESTORE = 4'd10,
    EV_ATTR    = 4'd11
  } event_kind_t;

  typedef struct packed {
    logic       bold;
    logic       italic;
    logic       underline;
    logic       reverse;
    logic [3:0] fore;
    logic [3:0] back;
    logic [7:0] size;
  } attr_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  char_code;
    logic [15:0] move;
    attr_t       attr;
    logic        font_changed;
  } event_t;

  localparam attr_t ATTR_DEFAULT = '{bold: 1'b0, italic: 1'b0, underline: 1'b0,
                                     reverse: 1'b0, fore: 4'd0, back: 4'd15,
                                     size: 8'd8};

  localparam logic [11:0] WIDTH_RESET = 12'd640;

  // 80 = 16 * 5: shift by four, then multiply by the reciprocal of five
  localparam int          COL_SHIFT   = 4;
  localparam logic [23:0] DIV5_RECIP  = 24'hCCCCCD;
  localparam int          RECIP_SHIFT = 26;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPERC = 8'h43;
  localparam logic [7:0] CH_UPPERG = 8'h47;
  localparam logic [7:0] CH_UPPERK = 8'h4B;
  localparam logic [7:0] CH_UPPERT = 8'h54;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LOWERM = 8'h6D;
  localparam logic [7:0] CH_LOWERS = 8'h73;
  localparam logic [7:0] CH_LOWERU = 8'h75;

  localparam logic [15:0] SGR_RESET      = 16'd0;
  localparam logic [15:0] SGR_BOLD       = 16'd1;
  localparam logic [15:0] SGR_ITALIC     = 16'd3;
  localparam logic [15:0] SGR_UNDERLINE  = 16'd4;
  localparam logic [15:0] SGR_REVERSE    = 16'd7;
  localparam logic [15:0] SGR_BOLD_OFF   = 16'd21;
  localparam logic [15:0] SGR_ITALIC_OFF = 16'd23;
  localparam logic [15:0] SGR_UNDER_OFF  = 16'd24;
  localparam logic [15:0] SGR_REV_OFF    = 16'd27;
  localparam logic [15:0] SGR_FORE_LO    = 16'd30;
  localparam logic [15:0] SGR_FORE_HI    = 16'd37;
  localparam logic [15:0] SGR_BACK_LO    = 16'd40;
  localparam logic [15:0] SGR_BACK_HI    = 16'd46;
  localparam logic [15:0] SGR_BACK_WHITE = 16'd47;

  localparam logic [3:0] COLOR_WHITE = 4'd15;

  function automatic logic [3:0] sgr_color(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd0:    c = 4'd0;
      3'd1:    c = 4'd4;
      3'd2:    c = 4'd2;
      3'd3:    c = 4'd6;
      3'd4:    c = 4'd1;
      3'd5:    c = 4'd5;
      3'd6:    c = 4'd3;
      default: c = 4'd7;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/ansi_csi_attribute_parser_core.sv
// ANSI CSI attribute parser: byte-stream parser plus a four-stage result pipeline.
// Depends on acap_pkg for types, codes and constants.
//
// Usage:
//   in_*  : one text byte per transaction in in_tdata[7:0].
//   out_* : one event per transaction; out_tuser carries the event kind,
//           out_tdata the character, move value and current attributes.
//   cfg_* : writes screen_width (cfg_data[11:0]); always ready. Write only
//           while the block is idle.
// A byte is parsed in the cycle it is accepted; parser state updates at that
// edge, so one byte is taken every cycle while in_tready is high. Bytes that
// cause no event (zero, ESC, digits, sequence openers) put nothing into the
// pipeline. An event passes four registers in order: parse, width product,
// reciprocal product and output, which drives out_*. The column-pixel divide
// by 80 is a shift plus a reciprocal multiply that sets this depth.
// Reset clears the parse mode, parameter, attributes (black on white, size
// 8), sets screen_width to 640 and empties the pipeline. When the receiver
// stalls, each stage holds; in_tready drops only once all four stages are
// full and the output is not taken.
module ansi_csi_attribute_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] input_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] char_code, [23:8] move_value, [24] bold_on,
                                   // [25] italic_on, [26] underline_on, [27] reverse_on,
                                   // [31:28] fore_color, [35:32] back_color,
                                   // [43:36] size_value, [44] font_changed, [47:45] zero
  output logic [3:0]  out_tuser,   // [3:0] event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data     // [11:0] screen_width
);

  acap_pkg::mode_t       mode_r, mode_nxt;
  logic [15:0]           acc_r, acc_nxt;
  acap_pkg::attr_t       attr_r, attr_nxt;
  logic [11:0]           width_r;

  logic                  in_acc;
  logic                  do_text;
  logic                  evt_v;
  acap_pkg::event_t      evt;

  logic [19:0]           acc_wide;
  logic [15:0]           acc_step;
  logic [3:0]            digit;
  logic                  is_digit;
  logic [7:0]            size_sat;

  acap_pkg::attr_t       sgr_attr;
  logic                  sgr_fc;
  logic [15:0]           fore_off;
  logic [15:0]           back_off;

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  en1, en2, en3, en4;
  acap_pkg::event_t      ev1_r, ev2_r, ev3_r, ev4_r;
  logic [27:0]           prod2_r, prod2_nxt;
  logic [47:0]           quot3_r, quot3_nxt;
  logic [21:0]           quot;
  acap_pkg::event_t      ev4_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= acap_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      width_r <= cfg_data;
    end
  end

  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_acc    = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= acap_pkg::CH_ZERO) && (in_tdata <= acap_pkg::CH_NINE);
  assign digit    = 4'(in_tdata - acap_pkg::CH_ZERO);
  assign acc_wide = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {16'd0, digit};
  assign acc_step = (|acc_wide[19:16]) ? 16'hFFFF : acc_wide[15:0];
  assign size_sat = (|acc_r[15:8]) ? 8'hFF : acc_r[7:0];
  assign fore_off = acc_r - acap_pkg::SGR_FORE_LO;
  assign back_off = acc_r - acap_pkg::SGR_BACK_LO;

  always_comb begin
    sgr_attr = attr_r;
    sgr_fc   = 1'b0;
    if (acc_r >= acap_pkg::SGR_FORE_LO && acc_r <= acap_pkg::SGR_FORE_HI) begin
      sgr_attr.fore = acap_pkg::sgr_color(fore_off[2:0]);
    end else if (acc_r >= acap_pkg::SGR_BACK_LO && acc_r <= acap_pkg::SGR_BACK_HI) begin
      sgr_attr.back = acap_pkg::sgr_color(back_off[2:0]);
    end else begin
      case (acc_r)
        acap_pkg::SGR_RESET: begin
          sgr_attr = acap_pkg::ATTR_DEFAULT;
          sgr_fc   = 1'b1;
        end
        acap_pkg::SGR_BOLD: begin
          sgr_attr.bold = 1'b1;
          sgr_fc        = 1'b1;
        end
        acap_pkg::SGR_ITALIC: begin
          sgr_attr.italic = 1'b1;
          sgr_fc          = 1'b1;
        end
        acap_pkg::SGR_BOLD_OFF: begin
          sgr_attr.bold = 1'b0;
          sgr_fc        = 1'b1;
        end
        acap_pkg::SGR_ITALIC_OFF: begin
          sgr_attr.italic = 1'b0;
          sgr_fc          = 1'b1;
        end
        acap_pkg::SGR_UNDERLINE:  sgr_attr.underline = 1'b1;
        acap_pkg::SGR_UNDER_OFF:  sgr_attr.underline = 1'b0;
        acap_pkg::SGR_REVERSE:    sgr_attr.reverse   = 1'b1;
        acap_pkg::SGR_REV_OFF:    sgr_attr.reverse   = 1'b0;
        acap_pkg::SGR_BACK_WHITE: sgr_attr.back      = acap_pkg::COLOR_WHITE;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    acc_nxt      = acc_r;
    attr_nxt     = attr_r;
    do_text      = 1'b0;
    evt_v        = 1'b0;
    evt.kind     = acap_pkg::EV_PRINT;
    evt.char_code = 8'd0;
    evt.move     = 16'd0;
    evt.font_changed = 1'b0;
    if (in_acc && in_tdata != 8'd0) begin
      unique case (mode_r)
        acap_pkg::MODE_TEXT: do_text = 1'b1;
        acap_pkg::MODE_ESC: begin
          if (in_tdata == acap_pkg::CH_LBRACK) begin
            mode_nxt = acap_pkg::MODE_CSI;
            acc_nxt  = 16'd0;
          end else begin
            mode_nxt = acap_pkg::MODE_TEXT;
            do_text  = 1'b1;
          end
        end
        acap_pkg::MODE_CSI: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else begin
            mode_nxt = acap_pkg::MODE_TEXT;
            case (in_tdata) inside
              acap_pkg::CH_SPACE: mode_nxt = acap_pkg::MODE_SPACE;
              acap_pkg::CH_UPPERK: begin
                evt_v    = 1'b1;
                evt.kind = acap_pkg::EV_CLR_EOL;
              end
              acap_pkg::CH_UPPERG: begin
                evt_v    = 1'b1;
                evt.kind = acap_pkg::EV_COLUMN;
                evt.move = acc_r;
              end
              acap_pkg::CH_UPPERT: begin
                evt_v    = 1'b1;
                evt.kind = acap_pkg::EV_COL_PIX;
                evt.move = acc_r;
              end
              acap_pkg::CH_LOWERS: begin
                evt_v    = 1'b1;
                evt.kind = acap_pkg::EV_SAVE;
              end
              acap_pkg::CH_LOWERU: begin
                evt_v    = 1'b1;
                evt.kind = acap_pkg::EV_RESTORE;
              end
              acap_pkg::CH_SEMI, acap_pkg::CH_LOWERM: begin
                evt_v            = 1'b1;
                evt.kind         = acap_pkg::EV_ATTR;
                evt.font_changed = sgr_fc;
                attr_nxt         = sgr_attr;
                if (in_tdata == acap_pkg::CH_SEMI) begin
                  mode_nxt = acap_pkg::MODE_CSI;
                  acc_nxt  = 16'd0;
                end
              end
              default: ;
            endcase
          end
        end
        acap_pkg::MODE_SPACE: begin
          mode_nxt = acap_pkg::MODE_TEXT;
          if (in_tdata == acap_pkg::CH_UPPERC) begin
            attr_nxt.size    = size_sat;
            evt_v            = 1'b1;
            evt.kind         = acap_pkg::EV_ATTR;
            evt.font_changed = 1'b1;
          end else if (in_tdata == acap_pkg::CH_SEMI) begin
            mode_nxt = acap_pkg::MODE_CSI;
            acc_nxt  = 16'd0;
          end
        end
        default: mode_nxt = acap_pkg::MODE_TEXT;
      endcase
      if (do_text) begin
        evt_v = 1'b1;
        case (in_tdata)
          acap_pkg::CH_BEL: evt.kind = acap_pkg::EV_BEEP;
          acap_pkg::CH_TAB: evt.kind = acap_pkg::EV_TAB;
          acap_pkg::CH_LF:  evt.kind = acap_pkg::EV_NEWLINE;
          acap_pkg::CH_CR:  evt.kind = acap_pkg::EV_RETURN;
          acap_pkg::CH_FF: begin
            evt.kind         = acap_pkg::EV_CLS;
            evt.font_changed = 1'b1;
            attr_nxt         = acap_pkg::ATTR_DEFAULT;
          end
          acap_pkg::CH_ESC: begin
            evt_v    = 1'b0;
            mode_nxt = acap_pkg::MODE_ESC;
          end
          default: begin
            evt.kind      = acap_pkg::EV_PRINT;
            evt.char_code = in_tdata;
          end
        endcase
      end
    end
    evt.attr = attr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= acap_pkg::MODE_TEXT;
      acc_r  <= 16'd0;
      attr_r <= acap_pkg::ATTR_DEFAULT;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      attr_r <= attr_nxt;
    end
  end

  assign prod2_nxt = 28'(ev1_r.move) * 28'(width_r);
  assign quot3_nxt = 48'(prod2_r[27:acap_pkg::COL_SHIFT]) * 48'(acap_pkg::DIV5_RECIP);
  assign quot      = quot3_r[47:acap_pkg::RECIP_SHIFT];

  always_comb begin
    ev4_nxt = ev3_r;
    if (ev3_r.kind == acap_pkg::EV_COL_PIX) begin
      ev4_nxt.move = (|quot[21:16]) ? 16'hFFFF : quot[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_acc && evt_v;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_acc && evt_v) begin
      ev1_r <= evt;
    end
    if (en2 && v1_r) begin
      ev2_r   <= ev1_r;
      prod2_r <= prod2_nxt;
    end
    if (en3 && v2_r) begin
      ev3_r   <= ev2_r;
      quot3_r <= quot3_nxt;
    end
    if (en4 && v3_r) begin
      ev4_r <= ev4_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = ev4_r.kind;
  assign out_tdata  = {3'b000, ev4_r.font_changed, ev4_r.attr.size, ev4_r.attr.back,
                       ev4_r.attr.fore, ev4_r.attr.reverse, ev4_r.attr.underline,
                       ev4_r.attr.italic, ev4_r.attr.bold, ev4_r.move, ev4_r.char_code};

  a_zero_byte_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata == 8'd0) |=> ($stable(mode_r) && $stable(acc_r) && $stable(attr_r)))
    else $error("zero byte changed parser state");

  a_csi_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_r == acap_pkg::MODE_ESC && in_tdata == acap_pkg::CH_LBRACK)
    |=> (mode_r == acap_pkg::MODE_CSI && acc_r == 16'd0))
    else $error("ESC [ did not open a sequence with a cleared parameter");

  a_char_only_print: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != acap_pkg::EV_PRINT) |-> (out_tdata[7:0] == 8'd0))
    else $error("non-print event carries a character");

  a_move_only_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != acap_pkg::EV_COLUMN && out_tuser != acap_pkg::EV_COL_PIX)
    |-> (out_tdata[23:8] == 16'd0))
    else $error("move value set on a non-column event");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= acap_pkg::EV_ATTR))
    else $error("event kind out of range");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for ansi_csi_attribute_parser_core: byte stream in, events out.
// Predicts each event from its own parser state and compares it field by field.
// Depends on acap_pkg and the core module only.
module tb;
  import acap_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = 12'd0;

  localparam logic [31:0] PALETTE = {4'd7, 4'd3, 4'd5, 4'd1, 4'd6, 4'd2, 4'd4, 4'd0};
  localparam logic [7:0]  CH_UPPERA = 8'h41;

  int sgr_known [10] = '{0, 1, 3, 4, 7, 21, 23, 24, 27, 47};

  mode_t       pmode = MODE_TEXT;
  logic [15:0] pacc = 16'd0;
  attr_t       attr = ATTR_DEFAULT;
  logic [11:0] width_q = WIDTH_RESET;

  logic [7:0] byte_queue [$];
  event_t     event_queue [$];
  event_t     drive_ev;
  event_t     want;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         events_seen = 0;

  ansi_csi_attribute_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit text_event(input logic [7:0] b, output event_kind_t k,
                                    output logic [7:0] ch, output logic fc);
    k = EV_PRINT;
    ch = 8'h00;
    fc = 1'b0;
    text_event = 1'b1;
    case (b)
      CH_BEL: k = EV_BEEP;
      CH_TAB: k = EV_TAB;
      CH_FF: begin
        k = EV_CLS;
        attr = ATTR_DEFAULT;
        fc = 1'b1;
      end
      CH_ESC: begin
        pmode = MODE_ESC;
        text_event = 1'b0;
      end
      CH_LF: k = EV_NEWLINE;
      CH_CR: k = EV_RETURN;
      default: ch = b;
    endcase
  endfunction

  function automatic bit predict_event(input logic [7:0] b, output event_t ev);
    logic [19:0] acc_next;
    logic [27:0] pix;
    logic [2:0]  cidx;
    event_kind_t k;
    logic [7:0]  ch;
    logic [15:0] mv;
    logic        fc;
    bit          hit;
    hit = 1'b0;
    k = EV_PRINT;
    ch = 8'h00;
    mv = 16'd0;
    fc = 1'b0;
    if (b != 8'h00) begin
      case (pmode)
        MODE_ESC: begin
          if (b == CH_LBRACK) begin
            pmode = MODE_CSI;
            pacc = 16'd0;
          end else begin
            pmode = MODE_TEXT;
            hit = text_event(b, k, ch, fc);
          end
        end
        MODE_CSI: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            acc_next = 20'(pacc) * 20'd10 + 20'(b - CH_ZERO);
            pacc = (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];
          end else begin
            pmode = MODE_TEXT;
            hit = 1'b1;
            case (b)
              CH_SPACE: begin
                pmode = MODE_SPACE;
                hit = 1'b0;
              end
              CH_UPPERK: k = EV_CLR_EOL;
              CH_UPPERG: begin
                k = EV_COLUMN;
                mv = pacc;
              end
              CH_UPPERT: begin
                k = EV_COL_PIX;
                pix = 28'(pacc) * 28'(width_q);
                pix = pix / 28'd80;
                mv = (pix > 28'd65535) ? 16'hFFFF : pix[15:0];
              end
              CH_LOWERS: k = EV_SAVE;
              CH_LOWERU: k = EV_RESTORE;
              CH_SEMI, CH_LOWERM: begin
                k = EV_ATTR;
                if (pacc >= SGR_FORE_LO && pacc <= SGR_FORE_HI) begin
                  cidx = 3'(pacc - SGR_FORE_LO);
                  attr.fore = PALETTE[cidx*4 +: 4];
                end else if (pacc >= SGR_BACK_LO && pacc <= SGR_BACK_HI) begin
                  cidx = 3'(pacc - SGR_BACK_LO);
                  attr.back = PALETTE[cidx*4 +: 4];
                end else begin
                  case (pacc)
                    SGR_RESET: begin
                      attr = ATTR_DEFAULT;
                      fc = 1'b1;
                    end
                    SGR_BOLD: begin
                      attr.bold = 1'b1;
                      fc = 1'b1;
                    end
                    SGR_ITALIC: begin
                      attr.italic = 1'b1;
                      fc = 1'b1;
                    end
                    SGR_UNDERLINE: attr.underline = 1'b1;
                    SGR_REVERSE: attr.reverse = 1'b1;
                    SGR_BOLD_OFF: begin
                      attr.bold = 1'b0;
                      fc = 1'b1;
                    end
                    SGR_ITALIC_OFF: begin
                      attr.italic = 1'b0;
                      fc = 1'b1;
                    end
                    SGR_UNDER_OFF: attr.underline = 1'b0;
                    SGR_REV_OFF: attr.reverse = 1'b0;
                    SGR_BACK_WHITE: attr.back = COLOR_WHITE;
                    default: ;
                  endcase
                end
                if (b == CH_SEMI) begin
                  pmode = MODE_CSI;
                  pacc = 16'd0;
                end
              end
              default: hit = 1'b0;
            endcase
          end
        end
        MODE_SPACE: begin
          pmode = MODE_TEXT;
          if (b == CH_UPPERC) begin
            attr.size = (pacc > 16'd255) ? 8'hFF : pacc[7:0];
            k = EV_ATTR;
            fc = 1'b1;
            hit = 1'b1;
          end else if (b == CH_SEMI) begin
            pmode = MODE_CSI;
            pacc = 16'd0;
          end
        end
        default: hit = text_event(b, k, ch, fc);
      endcase
    end
    ev.kind = k;
    ev.char_code = ch;
    ev.move = mv;
    ev.attr = attr;
    ev.font_changed = fc;
    return hit;
  endfunction

  task automatic log_mismatch(input string what, input logic [15:0] got,
                              input logic [15:0] exp_val);
    mismatches++;
    $display("tb: mismatch on %s at event %0d: got %0h, want %0h",
             what, events_seen, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        bytes_sent++;
        if (predict_event(in_tdata, drive_ev)) event_queue.push_back(drive_ev);
      end
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_tdata <= byte_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        events_seen++;
        if (event_queue.size() == 0) begin
          log_mismatch("unexpected event", 16'(out_tuser), 16'd0);
        end else begin
          want = event_queue.pop_front();
          if (out_tuser !== want.kind)
            log_mismatch("event_kind", 16'(out_tuser), 16'(want.kind));
          if (out_tdata[7:0] !== want.char_code)
            log_mismatch("char_code", 16'(out_tdata[7:0]), 16'(want.char_code));
          if (out_tdata[23:8] !== want.move)
            log_mismatch("move_value", out_tdata[23:8], want.move);
          if (out_tdata[24] !== want.attr.bold)
            log_mismatch("bold_on", 16'(out_tdata[24]), 16'(want.attr.bold));
          if (out_tdata[25] !== want.attr.italic)
            log_mismatch("italic_on", 16'(out_tdata[25]), 16'(want.attr.italic));
          if (out_tdata[26] !== want.attr.underline)
            log_mismatch("underline_on", 16'(out_tdata[26]), 16'(want.attr.underline));
          if (out_tdata[27] !== want.attr.reverse)
            log_mismatch("reverse_on", 16'(out_tdata[27]), 16'(want.attr.reverse));
          if (out_tdata[31:28] !== want.attr.fore)
            log_mismatch("fore_color", 16'(out_tdata[31:28]), 16'(want.attr.fore));
          if (out_tdata[35:32] !== want.attr.back)
            log_mismatch("back_color", 16'(out_tdata[35:32]), 16'(want.attr.back));
          if (out_tdata[43:36] !== want.attr.size)
            log_mismatch("size_value", 16'(out_tdata[43:36]), 16'(want.attr.size));
          if (out_tdata[44] !== want.font_changed)
            log_mismatch("font_changed", 16'(out_tdata[44]), 16'(want.font_changed));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_digits(input int unsigned v);
    logic [7:0] digs [$];
    do begin
      digs.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) byte_queue.push_back(digs[i]);
  endtask

  function automatic int unsigned random_param();
    case ($urandom_range(4))
      0: return $urandom_range(9);
      1: return $urandom_range(10, 99);
      2: return $urandom_range(999);
      3: return $urandom_range(65535);
      default: return $urandom_range(60000, 999999);
    endcase
  endfunction

  function automatic int unsigned random_sgr_code();
    int r;
    r = $urandom_range(9);
    if (r <= 5) return sgr_known[4'($urandom_range(9))];
    if (r == 6) return $urandom_range(30, 37);
    if (r == 7) return $urandom_range(40, 47);
    if (r == 8) return $urandom_range(99);
    return random_param();
  endfunction

  task automatic queue_random(input int n);
    int r;
    int cnt;
    while (byte_queue.size() < n) begin
      r = $urandom_range(99);
      if (r < 30) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) byte_queue.push_back(8'($urandom_range(255)));
      end else if (r < 65) begin
        byte_queue.push_back(CH_ESC);
        byte_queue.push_back(CH_LBRACK);
        cnt = $urandom_range(1, 3);
        for (int i = 0; i < cnt; i++) begin
          if ($urandom_range(7) == 0) byte_queue.push_back(CH_ZERO);
          if ($urandom_range(7) != 0) push_digits(random_sgr_code());
          byte_queue.push_back((i == cnt - 1) ? CH_LOWERM : CH_SEMI);
        end
      end else if (r < 80) begin
        byte_queue.push_back(CH_ESC);
        byte_queue.push_back(CH_LBRACK);
        if ($urandom_range(5) != 0) push_digits(random_param());
        case ($urandom_range(4))
          0: byte_queue.push_back(CH_UPPERK);
          1: byte_queue.push_back(CH_UPPERG);
          2: byte_queue.push_back(CH_UPPERT);
          3: byte_queue.push_back(CH_LOWERS);
          default: byte_queue.push_back(CH_LOWERU);
        endcase
      end else if (r < 90) begin
        byte_queue.push_back(CH_ESC);
        byte_queue.push_back(CH_LBRACK);
        push_digits($urandom_range(1) ? $urandom_range(300) : random_param());
        byte_queue.push_back(CH_SPACE);
        cnt = $urandom_range(19);
        if (cnt < 14) begin
          byte_queue.push_back(CH_UPPERC);
        end else if (cnt < 17) begin
          byte_queue.push_back(CH_SEMI);
          push_digits(random_sgr_code());
          byte_queue.push_back(CH_LOWERM);
        end else begin
          byte_queue.push_back(8'($urandom_range(255)));
        end
      end else begin
        case ($urandom_range(3))
          0: begin
            byte_queue.push_back(CH_ESC);
            byte_queue.push_back(8'($urandom_range(255)));
          end
          1: begin
            byte_queue.push_back(CH_ESC);
            byte_queue.push_back(CH_LBRACK);
            push_digits(random_param());
            byte_queue.push_back(8'($urandom_range(255)));
          end
          2: begin
            byte_queue.push_back(CH_ESC);
            byte_queue.push_back(8'h00);
            byte_queue.push_back(CH_LBRACK);
            push_digits($urandom_range(47));
            byte_queue.push_back(8'h00);
            byte_queue.push_back(CH_LOWERM);
          end
          default: begin
            byte_queue.push_back(CH_ESC);
            byte_queue.push_back(CH_LBRACK);
            push_digits($urandom_range(99));
            byte_queue.push_back(CH_ESC);
            byte_queue.push_back(CH_LBRACK);
          end
        endcase
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_tvalid || event_queue.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_width(input logic [11:0] w);
    @(posedge clk);
    cfg_data <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_q = w;
  endtask

  initial begin
    logic [11:0] w;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(CH_BEL);
    byte_queue.push_back(CH_TAB);
    byte_queue.push_back(CH_LF);
    byte_queue.push_back(CH_CR);
    byte_queue.push_back(CH_ESC);
    byte_queue.push_back(CH_UPPERA);
    byte_queue.push_back(CH_ESC);
    byte_queue.push_back(CH_LBRACK);
    push_digits(99999);
    byte_queue.push_back(CH_UPPERT);
    byte_queue.push_back(CH_ESC);
    byte_queue.push_back(CH_LBRACK);
    push_digits(300);
    byte_queue.push_back(CH_SPACE);
    byte_queue.push_back(CH_UPPERC);
    byte_queue.push_back(CH_FF);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: w = 12'd1;
        1: w = 12'd4095;
        3: w = 12'd80;
        4: w = 12'd4095;
        5: w = 12'd1;
        default: w = 12'($urandom_range(1, 4095));
      endcase
      write_width(w);
      sender_idle_pct = (p % 4 == 1) ? 82 : (p % 4 == 3) ? 29 : 0;
      recv_stall_pct = (p % 4 == 2) ? 82 : (p % 4 == 3) ? 29 : 0;
      queue_random(125);
      wait_drained();
    end

    $display("summary: %0d bytes accepted, %0d events checked, 9 width settings", bytes_sent,
             events_seen);
    $display("summary: idle patterns none, sender 82%%, receiver 82%%, both 29%%");
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
sv/acap_pkg.sv
sv/ansi_csi_attribute_parser_core.sv
tb/sv/tb.sv
